FILE: rtl/core/tsvlcs_pkg.sv
`default_nettype none

package tsvlcs_pkg;

  // Column buffer depth and the widths that follow from it.
  localparam int unsigned COLUMN_DEPTH = 64;
  localparam int unsigned ADDR_W       = (COLUMN_DEPTH > 1) ? $clog2(COLUMN_DEPTH) : 1;
  localparam int unsigned LEN_W        = $clog2(COLUMN_DEPTH + 1);

  // Input word kinds.
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Characters with a meaning to the parser.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;

endpackage : tsvlcs_pkg

`default_nettype wire

FILE: rtl/core/tsv_line_column_splitter.sv
// TSV line and column splitter.
// Input channel (in_valid_i / in_ready_o): one word per text byte (kind_i = 0,
// data_byte_i) or an end-of-text marker (kind_i = 1). Output channel
// (out_valid_o / out_ready_i): one word per column byte, with column_last_o
// and line_last_o marking the ends of columns and lines; an empty column gives
// a single word with byte_valid_o = 0. Columns split at TAB, lines at CR LF.
// Quoted columns lose their outer quotes and doubled quotes collapse.
// Bytes of a column go into a single-port-write, registered-read buffer of
// COLUMN_DEPTH bytes; extra bytes are dropped and overflow_o is set on every
// word of that column.
// Intake: plain text bytes are taken while the block is idle; a CR followed by
// other content also passes through ST_PUT2 to store the byte after the CR.
// Closing a column steps through setup, then a read and an evaluate for each
// byte read back from the buffer, then the end check and finish; the buffer's
// registered read sets this pace. Input is not taken while a column drains.
// Reset: parser goes between columns, column empty, output empty. Buffer
// contents stay undefined and are never read before written.
// Receiver stall: the output register holds its word, and draining waits.
`default_nettype none

module tsv_line_column_splitter (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       kind_i,
  input  wire logic [7:0] data_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            column_last_o,
  output logic            line_last_o,
  output logic            overflow_o
);
  import tsvlcs_pkg::*;

  typedef enum logic [1:0] {PS_BETWEEN, PS_COLUMN, PS_AFTER_CR} parse_e;
  typedef enum logic [2:0] {ST_IDLE, ST_PUT2, ST_SETUP, ST_RD, ST_EV, ST_FIN} ctl_e;

  // Column buffer: written at the fill point, read one entry at a time.
  logic [7:0]        mem [COLUMN_DEPTH];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [7:0]        rdata_q;

  parse_e           ps_q, ps_d;
  ctl_e             ctl_q, ctl_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       first_q, first_d;
  logic [7:0]       last_q, last_d;
  logic             ovf_q, ovf_d;
  logic             lhc_q, lhc_d;      // a column of this line has closed
  logic             le_q, le_d;        // the closing column ends the line
  logic [7:0]       c2_q, c2_d;        // byte stored after a lone CR
  logic             quoted_q, quoted_d;
  logic [LEN_W-1:0] hi_q, hi_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic [7:0]       held_q, held_d;    // candidate byte awaiting its successor
  logic             held_v_q, held_v_d;
  logic             pend_q, pend_d;    // last kept byte was an unpaired quote

  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             byte_valid_q, byte_valid_d;
  logic             col_last_q, col_last_d;
  logic             line_last_q, line_last_d;
  logic             out_ovf_q, out_ovf_d;

  logic             in_fire;
  logic             can_push;
  logic             push;
  logic             wr_req;
  logic [7:0]       wr_byte;
  logic             skip;

  assign in_ready_o = (ctl_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign can_push   = !out_valid_q || out_ready_i;
  assign skip       = quoted_q && pend_q && (rdata_q == CH_QUOTE);
  assign wr_addr    = len_q[ADDR_W-1:0];
  assign wr_data    = wr_byte;

  always_comb begin
    ps_d     = ps_q;
    ctl_d    = ctl_q;
    len_d    = len_q;
    first_d  = first_q;
    last_d   = last_q;
    ovf_d    = ovf_q;
    lhc_d    = lhc_q;
    le_d     = le_q;
    c2_d     = c2_q;
    quoted_d = quoted_q;
    hi_d     = hi_q;
    idx_d    = idx_q;
    held_d   = held_q;
    held_v_d = held_v_q;
    pend_d   = pend_q;
    wr_req   = 1'b0;
    wr_byte  = data_byte_i;
    rd_en    = 1'b0;
    push     = 1'b0;
    out_byte_d   = out_byte_q;
    byte_valid_d = byte_valid_q;
    col_last_d   = col_last_q;
    line_last_d  = line_last_q;
    out_ovf_d    = out_ovf_q;

    unique case (ctl_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (kind_i == KIND_END) begin
            // Close whatever is pending, then start over between columns.
            unique case (ps_q)
              PS_COLUMN: begin
                le_d  = 1'b1;
                ctl_d = ST_SETUP;
              end
              PS_AFTER_CR: begin
                wr_req  = 1'b1;
                wr_byte = CH_CR;
                le_d    = 1'b1;
                ctl_d   = ST_SETUP;
              end
              default: begin
                if (lhc_q) begin
                  le_d  = 1'b1;
                  ctl_d = ST_SETUP;
                end
              end
            endcase
            ps_d  = PS_BETWEEN;
            lhc_d = 1'b0;
          end else begin
            unique case (ps_q)
              PS_COLUMN: begin
                if (data_byte_i == CH_TAB) begin
                  le_d  = 1'b0;
                  lhc_d = 1'b1;
                  ps_d  = PS_BETWEEN;
                  ctl_d = ST_SETUP;
                end else if (data_byte_i == CH_CR) begin
                  ps_d = PS_AFTER_CR;
                end else begin
                  wr_req = 1'b1;
                end
              end
              PS_AFTER_CR: begin
                if (data_byte_i == CH_LF) begin
                  le_d  = 1'b1;
                  lhc_d = 1'b0;
                  ps_d  = PS_BETWEEN;
                  ctl_d = ST_SETUP;
                end else if (data_byte_i == CH_CR) begin
                  wr_req  = 1'b1;
                  wr_byte = CH_CR;
                end else begin
                  // Keep the CR as content and store the byte next cycle.
                  wr_req  = 1'b1;
                  wr_byte = CH_CR;
                  c2_d    = data_byte_i;
                  ps_d    = PS_COLUMN;
                  ctl_d   = ST_PUT2;
                end
              end
              default: begin
                if (data_byte_i == CH_TAB) begin
                  le_d  = 1'b0;
                  lhc_d = 1'b1;
                  ps_d  = PS_BETWEEN;
                  ctl_d = ST_SETUP;
                end else if (data_byte_i == CH_CR) begin
                  ps_d = PS_AFTER_CR;
                end else begin
                  wr_req = 1'b1;
                  ps_d   = PS_COLUMN;
                end
              end
            endcase
          end
        end
      end
      ST_PUT2: begin
        wr_req  = 1'b1;
        wr_byte = c2_q;
        ctl_d   = ST_IDLE;
      end
      ST_SETUP: begin
        // Quote test on the first and last stored bytes.
        quoted_d = (len_q >= LEN_W'(2)) && (first_q == CH_QUOTE) && (last_q == CH_QUOTE);
        idx_d    = quoted_d ? LEN_W'(1) : '0;
        hi_d     = quoted_d ? (len_q - LEN_W'(1)) : len_q;
        held_v_d = 1'b0;
        pend_d   = 1'b0;
        ctl_d    = ST_RD;
      end
      ST_RD: begin
        if (idx_q < hi_q) begin
          rd_en = 1'b1;
          ctl_d = ST_EV;
        end else begin
          ctl_d = ST_FIN;
        end
      end
      ST_EV: begin
        if (skip) begin
          // Drop the second quote of a doubled pair.
          pend_d = 1'b0;
          idx_d  = idx_q + LEN_W'(1);
          ctl_d  = ST_RD;
        end else if (!held_v_q || can_push) begin
          if (held_v_q) begin
            push         = 1'b1;
            out_byte_d   = held_q;
            byte_valid_d = 1'b1;
            col_last_d   = 1'b0;
            line_last_d  = 1'b0;
            out_ovf_d    = ovf_q;
          end
          held_d   = rdata_q;
          held_v_d = 1'b1;
          pend_d   = quoted_q && (rdata_q == CH_QUOTE);
          idx_d    = idx_q + LEN_W'(1);
          ctl_d    = ST_RD;
        end
      end
      ST_FIN: begin
        if (can_push) begin
          push         = 1'b1;
          out_byte_d   = held_v_q ? held_q : 8'h00;
          byte_valid_d = held_v_q;
          col_last_d   = 1'b1;
          line_last_d  = le_q;
          out_ovf_d    = ovf_q;
          len_d        = '0;
          ovf_d        = 1'b0;
          held_v_d     = 1'b0;
          ctl_d        = ST_IDLE;
        end
      end
      default: ctl_d = ST_IDLE;
    endcase

    // Append to the column, or flag the overflow once it is full.
    wr_en = 1'b0;
    if (wr_req) begin
      if (len_q < LEN_W'(COLUMN_DEPTH)) begin
        wr_en  = 1'b1;
        len_d  = len_q + LEN_W'(1);
        last_d = wr_byte;
        if (len_q == '0) begin
          first_d = wr_byte;
        end
      end else begin
        ovf_d = 1'b1;
      end
    end

    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q         <= PS_BETWEEN;
      ctl_q        <= ST_IDLE;
      len_q        <= '0;
      ovf_q        <= 1'b0;
      lhc_q        <= 1'b0;
      le_q         <= 1'b0;
      held_v_q     <= 1'b0;
      pend_q       <= 1'b0;
      quoted_q     <= 1'b0;
      hi_q         <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      first_q      <= '0;
      last_q       <= '0;
      c2_q         <= '0;
      held_q       <= '0;
      out_byte_q   <= '0;
      byte_valid_q <= 1'b0;
      col_last_q   <= 1'b0;
      line_last_q  <= 1'b0;
      out_ovf_q    <= 1'b0;
    end else begin
      ps_q         <= ps_d;
      ctl_q        <= ctl_d;
      len_q        <= len_d;
      ovf_q        <= ovf_d;
      lhc_q        <= lhc_d;
      le_q         <= le_d;
      held_v_q     <= held_v_d;
      pend_q       <= pend_d;
      quoted_q     <= quoted_d;
      hi_q         <= hi_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
      first_q      <= first_d;
      last_q       <= last_d;
      c2_q         <= c2_d;
      held_q       <= held_d;
      out_byte_q   <= out_byte_d;
      byte_valid_q <= byte_valid_d;
      col_last_q   <= col_last_d;
      line_last_q  <= line_last_d;
      out_ovf_q    <= out_ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[idx_q[ADDR_W-1:0]];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_valid_o  = byte_valid_q;
  assign column_last_o = col_last_q;
  assign line_last_o   = line_last_q;
  assign overflow_o    = out_ovf_q;

  // The fill count never passes the buffer depth.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(COLUMN_DEPTH))
    else $error("column length beyond buffer depth");

  // No buffer write while a column drains.
  a_no_wr_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q == ST_RD || ctl_q == ST_EV || ctl_q == ST_FIN) |-> !wr_en)
    else $error("buffer written while draining");

  // An overflowed column has a full buffer.
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (len_q == LEN_W'(COLUMN_DEPTH)))
    else $error("overflow without full buffer");

  // An empty-column word and a line end always close the column.
  a_col_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (!byte_valid_q || line_last_q)) |-> col_last_q)
    else $error("empty column or line end without column end");

  // Reads stay inside the stored part of the column.
  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (idx_q < len_q))
    else $error("buffer read beyond fill point");

endmodule : tsv_line_column_splitter

`default_nettype wire

FILE: tb/tsv_split_checker.sv
module tsv_split_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        byte_valid_i,
  input  logic        column_last_i,
  input  logic        line_last_i,
  input  logic        overflow_i,
  output int unsigned fail_count_o,
  output int unsigned words_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tsvlcs_pkg::*;

  typedef enum logic [1:0] {
    PARSE_BETWEEN  = 2'd0,
    PARSE_COLUMN   = 2'd1,
    PARSE_AFTER_CR = 2'd2
  } parse_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_byte;
    logic       col_end;
    logic       line_end;
    logic       trunc;
  } column_word_t;

  column_word_t expected_words[$];
  logic [7:0]   column_buf [COLUMN_DEPTH];
  int unsigned  column_len;
  bit           line_open;
  bit           truncated;
  parse_e       parse_state;
  int unsigned  mismatches;

  // Append one predicted word to the tail of the queue.
  function automatic void expect_word(input column_word_t w);
    expected_words = {expected_words, w};
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    if (column_len < COLUMN_DEPTH) begin
      column_buf[column_len] = b;
      column_len++;
    end else begin
      truncated = 1'b1;
    end
  endfunction

  // Unquote the stored bytes and queue one word per byte, or a single
  // byte-less word for an empty column.
  function automatic void close_column(input bit line_end);
    logic [7:0]  kept [$];
    int unsigned n;
    int unsigned i;
    bit          ovf;
    n   = column_len;
    ovf = truncated;
    if (n >= 2 && column_buf[0] == CH_QUOTE && column_buf[n-1] == CH_QUOTE) begin
      i = 1;
      while (i + 1 < n - 1) begin
        kept = {kept, column_buf[i]};
        if (column_buf[i] == CH_QUOTE && column_buf[i+1] == CH_QUOTE) i += 2;
        else i += 1;
      end
      if (i + 1 == n - 1) kept = {kept, column_buf[i]};
    end else begin
      for (i = 0; i < n; i++) kept = {kept, column_buf[i]};
    end
    column_len = 0;
    truncated  = 1'b0;
    if (kept.size() == 0) begin
      expect_word('{8'h00, 1'b0, 1'b1, line_end, ovf});
    end else begin
      for (i = 0; i < kept.size(); i++) begin
        expect_word('{kept[i], 1'b1, i + 1 == kept.size(),
                      (i + 1 == kept.size()) && line_end, ovf});
      end
    end
  endfunction

  function automatic void predict_columns(input logic k, input logic [7:0] b);
    if (k == KIND_END) begin
      case (parse_state)
        PARSE_COLUMN: close_column(1'b1);
        PARSE_AFTER_CR: begin
          push_byte(CH_CR);
          close_column(1'b1);
        end
        default: if (line_open) close_column(1'b1);
      endcase
      parse_state = PARSE_BETWEEN;
      line_open   = 1'b0;
      column_len  = 0;
      truncated   = 1'b0;
      return;
    end
    case (parse_state)
      PARSE_COLUMN: begin
        if (b == CH_TAB) begin
          close_column(1'b0);
          line_open   = 1'b1;
          parse_state = PARSE_BETWEEN;
        end else if (b == CH_CR) begin
          parse_state = PARSE_AFTER_CR;
        end else begin
          push_byte(b);
        end
      end
      PARSE_AFTER_CR: begin
        if (b == CH_LF) begin
          close_column(1'b1);
          line_open   = 1'b0;
          parse_state = PARSE_BETWEEN;
        end else if (b == CH_CR) begin
          push_byte(CH_CR);
        end else begin
          push_byte(CH_CR);
          push_byte(b);
          parse_state = PARSE_COLUMN;
        end
      end
      default: begin
        if (b == CH_TAB) begin
          close_column(1'b0);
          line_open   = 1'b1;
          parse_state = PARSE_BETWEEN;
        end else if (b == CH_CR) begin
          parse_state = PARSE_AFTER_CR;
        end else begin
          push_byte(b);
          parse_state = PARSE_COLUMN;
        end
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    column_word_t want;
    column_word_t got;
    if (!rst_ni) begin
      expected_words.delete();
      parse_state     = PARSE_BETWEEN;
      column_len      = 0;
      line_open       = 1'b0;
      truncated       = 1'b0;
      mismatches      = 0;
      fail_count_o    <= 0;
      words_pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{out_byte_i, byte_valid_i, column_last_i, line_last_i, overflow_i};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, got byte=%02h valid=%b col_last=%b line_last=%b ovf=%b",
                   $time, got.ch, got.has_byte, got.col_end, got.line_end, got.trunc);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected byte=%02h valid=%b col_last=%b line_last=%b ovf=%b",
                     $time, want.ch, want.has_byte, want.col_end, want.line_end, want.trunc);
            $display("%0t:           actual   byte=%02h valid=%b col_last=%b line_last=%b ovf=%b",
                     $time, got.ch, got.has_byte, got.col_end, got.line_end, got.trunc);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_columns(kind_i, data_byte_i);
      fail_count_o    <= mismatches;
      words_pending_o <= expected_words.size();
    end
  end

endmodule

FILE: tb/tsv_line_column_splitter_tb.sv
module tsv_line_column_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tsvlcs_pkg::*;

  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned PHASE_WORDS    = 78;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       kind_i        = KIND_TEXT;
  logic [7:0] data_byte_i   = 8'h00;
  logic       out_ready_i   = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       column_last_o;
  logic       line_last_o;
  logic       overflow_o;

  int unsigned fail_count;
  int unsigned words_pending;
  int unsigned words_sent = 0;
  // Chance, in percent, that the sender idles before a word / the receiver
  // holds ready low in a cycle.
  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;

  always #5 clk_i = ~clk_i;

  tsv_line_column_splitter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .column_last_o(column_last_o),
    .line_last_o  (line_last_o),
    .overflow_o   (overflow_o)
  );

  tsv_split_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_i     (out_byte_o),
    .byte_valid_i   (byte_valid_o),
    .column_last_i  (column_last_o),
    .line_last_i    (line_last_o),
    .overflow_i     (overflow_o),
    .fail_count_o   (fail_count),
    .words_pending_o(words_pending)
  );

  // Receiver: drop ready at random according to the current stall chance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offer one word, optionally after an idle stretch, and hold it until taken.
  task automatic send_word(input logic k, input logic [7:0] b);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < gap_pct) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(KIND_TEXT, b);
  endtask

  // End of text carries a random, ignored data byte.
  task automatic end_text();
    send_word(KIND_END, 8'($urandom_range(0, 255)));
  endtask

  // Any byte that does not split a column or start a line break.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_TAB || b == CH_CR);
    return b;
  endfunction

  // Hold off the sender until every predicted word has come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (words_pending != 0);
  endtask

  // Column longer than the buffer, sometimes wrapped in quotes.
  task automatic long_column();
    bit quoted;
    quoted = 1'($urandom_range(0, 1));
    if (quoted) send_byte(CH_QUOTE);
    repeat ($urandom_range(65, 70)) send_byte(plain_byte());
    if (quoted) send_byte(CH_QUOTE);
  endtask

  task automatic emit_column();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // empty column: nothing before the separator
    end else if (pick < 40) begin
      repeat ($urandom_range(1, 8)) send_byte(plain_byte());
    end else if (pick < 60) begin
      // quoted column with doubled and lone quotes mixed into the content
      send_byte(CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 3))
          0: begin
            send_byte(CH_QUOTE);
            send_byte(CH_QUOTE);
          end
          1:       send_byte(CH_QUOTE);
          default: send_byte(plain_byte());
        endcase
      end
      send_byte(CH_QUOTE);
    end else if (pick < 70) begin
      // carriage returns that do not end the line
      send_byte(plain_byte());
      case ($urandom_range(0, 2))
        0: begin
          send_byte(CH_CR);
          send_byte(plain_byte());
        end
        1: begin
          send_byte(CH_CR);
          send_byte(CH_CR);
          send_byte(plain_byte());
        end
        default: begin
          send_byte(CH_CR);
          send_byte(CH_TAB);
        end
      endcase
    end else if (pick < 72) begin
      long_column();
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 3)) send_byte(CH_QUOTE);
    end else begin
      // raw noise, separators and line feeds included
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic emit_separator();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send_byte(CH_TAB);
    end else if (pick < 83) begin
      send_byte(CH_CR);
      send_byte(CH_LF);
    end else if (pick < 91) begin
      end_text();
    end else if (pick < 95) begin
      send_byte(CH_TAB);
      end_text();
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly well-formed lines with random content, then settle.
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned n_words);
    int unsigned target;
    gap_pct   = send_pct;
    stall_pct <= recv_pct;
    target    = words_sent + n_words;
    while (words_sent < target) begin
      emit_column();
      emit_separator();
    end
    wait_idle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extreme byte values in a plain column.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_TAB);
    // Empty column.
    send_byte(CH_TAB);
    // Quoted doubled quote collapses to one quote.
    send_byte(CH_QUOTE);
    send_byte(CH_QUOTE);
    send_byte(CH_QUOTE);
    send_byte(CH_QUOTE);
    send_byte(CH_TAB);
    // Lone quote inside a quoted column passes through.
    send_byte(CH_QUOTE);
    send_byte(CH_QUOTE);
    send_byte("x");
    send_byte(CH_QUOTE);
    send_byte(CH_TAB);
    // Bare CRs stay in the column; only the CR right before LF is dropped.
    send_byte(CH_CR);
    send_byte("z");
    send_byte(CH_CR);
    send_byte(CH_CR);
    send_byte(CH_LF);
    // Tab after CR is content; end of text closes the pending column.
    send_byte(CH_CR);
    send_byte(CH_TAB);
    end_text();
    // Trailing tab at end of text gives an empty last column.
    send_byte(CH_TAB);
    end_text();
    // Nothing pending: end of text gives no word.
    end_text();
    // Pending CR at end of text is kept as content.
    send_byte("w");
    send_byte(CH_CR);
    end_text();
    wait_idle();

    // Make sure at least one column overflows the buffer.
    long_column();
    send_byte(CH_TAB);

    run_phase(0, 0, PHASE_WORDS);
    run_phase(75, 0, PHASE_WORDS);
    run_phase(0, 75, PHASE_WORDS);
    run_phase(14, 14, PHASE_WORDS);

    // Catch any stray words after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run.
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

endmodule
